// ----- src/pvp_pkg.sv -----
// ----------------------------------------------------------------------------
// pvp_pkg: shared types and constants of the perspective vertex projector
// Fixed-point widths, request and register codes, and the divider step.
// ----------------------------------------------------------------------------
package pvp_pkg;

  // fraction bits of all Q formats
  localparam int FRAC = 16;
  // quotient bits below the saturation cap
  localparam int QB = 40;
  // viewport size width
  localparam int VSW = 15;
  // clip-space sum width, magnitude width, remainder and product widths
  localparam int CW = 66 - FRAC;
  localparam int NW = CW + 1;
  localparam int RW = NW + 1;
  localparam int MW = NW + VSW;
  // signed quotient and screen sum widths
  localparam int SW = QB + 2;
  localparam int OW = SW + 2;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PROJ = 1'b1;

  // register indexes
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [31:0] cv;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } item_t;

  // one divider lane: partial remainder, dividend bits left, quotient so far
  typedef struct packed {
    logic [RW-1:0] r;
    logic [QB-1:0] l;
    logic [QB-1:0] q;
    logic          neg;
    logic          big;
  } lane_t;

  typedef struct packed {
    lane_t         lx;
    lane_t         ly;
    logic [NW-1:0] d;
    logic          wz;
  } div_t;

  // one restoring division step
  function automatic lane_t div_step(lane_t x, logic [NW-1:0] d);
    lane_t         y;
    logic [RW-1:0] r2;
    y  = x;
    r2 = {x.r[RW-2:0], x.l[QB-1]};
    y.l = {x.l[QB-2:0], 1'b0};
    if (r2 >= RW'(d)) begin
      y.r = r2 - RW'(d);
      y.q = {x.q[QB-2:0], 1'b1};
    end else begin
      y.r = r2;
      y.q = {x.q[QB-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

// ----- src/perspective_vertex_projector.sv -----
// ----------------------------------------------------------------------------
// perspective_vertex_projector: Q16.16 point to viewport projection
// Loads a column-major 4x4 matrix, then projects points to screen space.
//
//  channel  | direction | payload
//  in_*     | input     | tuser: req_type; tdata: index, coef, x, y, z
//  out_*    | output    | tuser: bad_result; tdata: screen_x, screen_y
//  cfg_*    | input     | register index and write data, no read-back
//
// one transaction per cycle while the output is not stalled; 46 register
// stages: four multiply and sum stages, divider setup, the 40-stage
// restoring divider with one quotient bit per stage, and the output
// register. synchronous active-low reset clears valids, store and viewport
// origin, and sets viewport width and height to 1024. a stalled output
// freezes the whole pipe; a one-entry input skid buffer takes one more
// transaction while a result waits.
// ----------------------------------------------------------------------------
module perspective_vertex_projector (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] coef_index, [35:4] coef_value, [67:36] point_x,
  // [99:68] point_y, [131:100] point_z, [135:132] zero
  input  logic [135:0] in_tdata,
  // [0] req_type
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] screen_x, [63:32] screen_y
  output logic [63:0]  out_tdata,
  // [0] bad_result
  output logic [0:0]   out_tuser,
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_wdata
);

  localparam int F  = pvp_pkg::FRAC;
  localparam int QB = pvp_pkg::QB;
  localparam int CW = pvp_pkg::CW;
  localparam int NW = pvp_pkg::NW;
  localparam int RW = pvp_pkg::RW;
  localparam int MW = pvp_pkg::MW;
  localparam int SW = pvp_pkg::SW;
  localparam int OW = pvp_pkg::OW;
  localparam int TW = MW - (QB - F);
  localparam logic signed [OW-1:0] S32_MAX = OW'(64'sd2147483647);
  localparam logic signed [OW-1:0] S32_MIN = OW'(-64'sd2147483648);

  // configuration registers
  logic [13:0]         ox_r, oy_r;
  logic [14:0]         vw_r, vh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      vw_r <= 15'd1024;
      vh_r <= 15'd1024;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pvp_pkg::REG_ORIGIN_X: ox_r <= cfg_wdata[13:0];
        pvp_pkg::REG_ORIGIN_Y: oy_r <= cfg_wdata[13:0];
        pvp_pkg::REG_WIDTH:    vw_r <= cfg_wdata;
        pvp_pkg::REG_HEIGHT:   vh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic                pipe_en;
  logic                out_vld_r;
  assign pipe_en = !out_vld_r || out_tready;

  // input skid buffer
  pvp_pkg::item_t      in_item, skid_r, ent;
  logic                skid_vld_r, in_fire, ent_vld;

  assign in_item = '{kind: in_tuser[0], idx: in_tdata[3:0], cv: in_tdata[35:4],
                     px: in_tdata[67:36], py: in_tdata[99:68], pz: in_tdata[131:100]};
  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign ent       = skid_vld_r ? skid_r : in_item;
  assign ent_vld   = skid_vld_r || in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (in_fire && !pipe_en) begin
      skid_vld_r <= 1'b1;
    end else if (pipe_en) begin
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !pipe_en) begin
      skid_r <= in_item;
    end
  end

  // coefficient store, written when a load transaction enters the pipe
  logic [31:0]         coef_r [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) coef_r[i] <= '0;
    end else if (pipe_en && ent_vld && ent.kind == pvp_pkg::REQ_LOAD) begin
      coef_r[ent.idx] <= ent.cv;
    end
  end

  // stage 1: nine products and three translation words (rows 0, 1, 3)
  logic signed [63:0]  prod_r [3][3];
  logic signed [31:0]  tr_r [3];
  logic                v1_r;

  for (genvar j = 0; j < 3; j++) begin : g_row
    // store position of the row's first column
    localparam logic [3:0] RB = (j == 2) ? 4'd3 : 4'(j);
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        prod_r[j][0] <= $signed(coef_r[RB])         * $signed(ent.px);
        prod_r[j][1] <= $signed(coef_r[RB + 4'd4])  * $signed(ent.py);
        prod_r[j][2] <= $signed(coef_r[RB + 4'd8])  * $signed(ent.pz);
        tr_r[j]      <= $signed(coef_r[RB + 4'd12]);
      end
    end
  end

  // stage 2: floor each product to Q.F and sum the row
  logic signed [CW-1:0] dot_r [3];
  logic                 v2_r;

  for (genvar j = 0; j < 3; j++) begin : g_sum
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dot_r[j] <= CW'(tr_r[j]) + CW'(prod_r[j][0] >>> F)
                  + CW'(prod_r[j][1] >>> F) + CW'(prod_r[j][2] >>> F);
      end
    end
  end

  // stage 3: numerators c + w, magnitudes and divisor 2|w|
  logic signed [NW-1:0] nx, ny;
  logic [CW-1:0]        absw;
  logic [NW-1:0]        ax_r, ay_r, d3_r;
  logic                 negx_r, negy_r, wz3_r, v3_r;

  assign nx   = NW'(dot_r[0]) + NW'(dot_r[2]);
  assign ny   = NW'(dot_r[1]) + NW'(dot_r[2]);
  assign absw = dot_r[2][CW-1] ? CW'(-dot_r[2]) : CW'(dot_r[2]);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ax_r   <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      ay_r   <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      negx_r <= nx[NW-1] != dot_r[2][CW-1];
      negy_r <= ny[NW-1] != dot_r[2][CW-1];
      d3_r   <= {absw, 1'b0};
      wz3_r  <= dot_r[2] == '0;
    end
  end

  // stage 4: scale by viewport size
  logic [MW-1:0]        mx_r, my_r;
  logic [NW-1:0]        d4_r;
  logic                 negx4_r, negy4_r, wz4_r, v4_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mx_r    <= MW'(ax_r) * MW'(vw_r);
      my_r    <= MW'(ay_r) * MW'(vh_r);
      d4_r    <= d3_r;
      negx4_r <= negx_r;
      negy4_r <= negy_r;
      wz4_r   <= wz3_r;
    end
  end

  // stage 5: cap test on the high dividend bits and divider setup
  pvp_pkg::div_t        div_r [QB+1];
  logic [QB:0]          dv_r;
  logic [TW-1:0]        tx, ty;

  assign tx = mx_r[MW-1:QB-F];
  assign ty = my_r[MW-1:QB-F];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      div_r[0].lx.r   <= RW'(tx);
      div_r[0].lx.l   <= {mx_r[QB-F-1:0], {F{1'b0}}};
      div_r[0].lx.q   <= '0;
      div_r[0].lx.neg <= negx4_r;
      div_r[0].lx.big <= RW'(tx) >= RW'(d4_r);
      div_r[0].ly.r   <= RW'(ty);
      div_r[0].ly.l   <= {my_r[QB-F-1:0], {F{1'b0}}};
      div_r[0].ly.q   <= '0;
      div_r[0].ly.neg <= negy4_r;
      div_r[0].ly.big <= RW'(ty) >= RW'(d4_r);
      div_r[0].d      <= d4_r;
      div_r[0].wz     <= wz4_r;
    end
  end

  // divider stages, one quotient bit each
  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        div_r[k+1].lx <= pvp_pkg::div_step(div_r[k].lx, div_r[k].d);
        div_r[k+1].ly <= pvp_pkg::div_step(div_r[k].ly, div_r[k].d);
        div_r[k+1].d  <= div_r[k].d;
        div_r[k+1].wz <= div_r[k].wz;
      end
    end
  end

  // valid bits travel with the data, projects only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      dv_r <= '0;
    end else if (pipe_en) begin
      v1_r <= ent_vld && ent.kind == pvp_pkg::REQ_PROJ;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r <= {dv_r[QB-1:0], v4_r};
    end
  end

  // final stage: sign, cap, viewport offset, flip and clamp
  logic signed [SW-1:0] qx, qy;
  logic signed [OW-1:0] sx, sy, offx, offy, hgt;
  logic [31:0]          cx, cy, out_x_r, out_y_r;
  logic                 badx, bady, out_bad_r;

  always_comb begin
    qx = div_r[QB].lx.big ? SW'(1) <<< QB : $signed(SW'(div_r[QB].lx.q));
    qy = div_r[QB].ly.big ? SW'(1) <<< QB : $signed(SW'(div_r[QB].ly.q));
    if (div_r[QB].lx.neg) qx = -qx;
    if (div_r[QB].ly.neg) qy = -qy;
    offx = $signed(OW'({ox_r, {F{1'b0}}}));
    offy = $signed(OW'({oy_r, {F{1'b0}}}));
    hgt  = $signed(OW'({vh_r, {F{1'b0}}}));
    sx   = OW'(qx) + offx;
    sy   = hgt - (OW'(qy) + offy);
    badx = 1'b1;
    bady = 1'b1;
    priority if (sx > S32_MAX) cx = 32'h7FFF_FFFF;
    else if (sx < S32_MIN)     cx = 32'h8000_0000;
    else begin
      cx   = sx[31:0];
      badx = 1'b0;
    end
    priority if (sy > S32_MAX) cy = 32'h7FFF_FFFF;
    else if (sy < S32_MIN)     cy = 32'h8000_0000;
    else begin
      cy   = sy[31:0];
      bady = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= dv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (div_r[QB].wz) begin
        out_x_r   <= 32'h7FFF_FFFF;
        out_y_r   <= 32'h7FFF_FFFF;
        out_bad_r <= 1'b1;
      end else begin
        out_x_r   <= cx;
        out_y_r   <= cy;
        out_bad_r <= badx || bady;
      end
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {out_y_r, out_x_r};
  assign out_tuser[0] = out_bad_r;

`ifndef SYNTHESIS
  // a frozen pipe keeps its stage-4 and divider valid bits
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(dv_r) && $stable(v4_r))
    else $error("pipe moved while stalled");

  // a buffered transaction is not dropped while stalled
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !pipe_en |=> skid_vld_r)
    else $error("skid entry lost");

  // zero divisor always reports a bad result
  a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && dv_r[QB] && div_r[QB].wz |=> out_tvalid && out_tuser[0])
    else $error("zero divisor not flagged");
`endif

endmodule
